[hw/rtl/mbe_pkg.sv]
`default_nettype none

package mbe_pkg;

  // Fixed-point format and field widths.
  localparam int FRAC_BITS   = 24;
  localparam int COORD_BITS  = 12;
  localparam int ITER_BITS   = 16;
  localparam int WORD_W      = 32;
  localparam int SIZE_W      = 13;
  localparam int STEP_W      = 31;
  localparam int SHADE_BITS  = 8;
  localparam int CFG_IDX_W   = 3;

  // Derived datapath widths.
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int MAP_W  = DIFF_W + WORD_W;
  localparam int PROD_W = 2 * WORD_W;
  localparam int SUM_W  = PROD_W + 2;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Escape threshold, 4.0 in the fixed-point format.
  localparam logic signed [SUM_W-1:0] ESCAPE_LIMIT = SUM_W'(4) << FRAC_BITS;

  // Saturation bounds of one word.
  localparam logic signed [SUM_W-1:0] WORD_HI = SUM_W'({1'b0, {(WORD_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] WORD_LO = -WORD_HI - SUM_W'(1);

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_CENTER_RE    = 3'd2,
    REG_CENTER_IM    = 3'd3,
    REG_STEP_RE      = 3'd4,
    REG_STEP_IM      = 3'd5,
    REG_MAX_ITER     = 3'd6
  } reg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [SIZE_W-1:0]        RST_WIDTH     = SIZE_W'(800);
  localparam logic [SIZE_W-1:0]        RST_HEIGHT    = SIZE_W'(600);
  localparam logic signed [WORD_W-1:0] RST_CENTER_RE = -WORD_W'(11843678);
  localparam logic signed [WORD_W-1:0] RST_CENTER_IM = -WORD_W'(4490436);
  localparam logic [STEP_W-1:0]        RST_STEP_RE   = STEP_W'(146801);
  localparam logic [STEP_W-1:0]        RST_STEP_IM   = STEP_W'(111848);
  localparam logic [ITER_BITS-1:0]     RST_MAX_ITER  = ITER_BITS'(800);

  // View settings used by the coordinate map.
  typedef struct packed {
    logic [SIZE_W-1:0]        width;
    logic [SIZE_W-1:0]        height;
    logic signed [WORD_W-1:0] center_re;
    logic signed [WORD_W-1:0] center_im;
    logic [STEP_W-1:0]        step_re;
    logic [STEP_W-1:0]        step_im;
  } view_cfg_t;

  // One mapped point c.
  typedef struct packed {
    logic signed [WORD_W-1:0] cx;
    logic signed [WORD_W-1:0] cy;
  } point_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_SUM
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_UPD,
    B_DONE
  } back_state_e;

  // Clamp a wide signed sum to the signed word range.
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > WORD_HI) begin
      r = WORD_HI[WORD_W-1:0];
    end else if (v < WORD_LO) begin
      r = WORD_LO[WORD_W-1:0];
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/mbe_pix_if.sv]
`default_nettype none

interface mbe_pix_if
  import mbe_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

[hw/rtl/mbe_res_if.sv]
`default_nettype none

interface mbe_res_if
  import mbe_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [ITER_BITS-1:0]  iter_count;
  logic [SHADE_BITS-1:0] shade;

  modport source (output valid, output iter_count, output shade, input ready);
  modport sink   (input valid, input iter_count, input shade, output ready);
endinterface

`default_nettype wire

[hw/rtl/mbe_front.sv]
`default_nettype none

module mbe_front
  import mbe_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire view_cfg_t     cfg_i,
  mbe_pix_if.sink            pix_i,
  input  wire queue_status_t q_status_i,
  output logic               push_o,
  output point_t             point_o
);

  front_state_e state_q, state_d;

  logic signed [DIFF_W-1:0] dx_q, dx_d, dy_q, dy_d;
  logic signed [MAP_W-1:0]  px_q, px_d, py_q, py_d;
  logic signed [MAP_W-1:0]  dx_ext, dy_ext, sx_ext, sy_ext;
  logic signed [SUM_W-1:0]  px_ext, py_ext, cre_ext, cim_ext;

  // Offset of the pixel from the image centre.
  assign dx_d = signed'({1'b0, pix_i.pixel_x}) - signed'({1'b0, cfg_i.width[SIZE_W-1:1]});
  assign dy_d = signed'({1'b0, pix_i.pixel_y}) - signed'({1'b0, cfg_i.height[SIZE_W-1:1]});

  // Offset times step.
  assign dx_ext = dx_q;
  assign dy_ext = dy_q;
  assign sx_ext = signed'(MAP_W'(cfg_i.step_re));
  assign sy_ext = signed'(MAP_W'(cfg_i.step_im));
  assign px_d   = dx_ext * sx_ext;
  assign py_d   = dy_ext * sy_ext;

  // Add the centre and saturate.
  assign px_ext  = px_q;
  assign py_ext  = py_q;
  assign cre_ext = cfg_i.center_re;
  assign cim_ext = cfg_i.center_im;
  assign point_o.cx = sat_word(px_ext + cre_ext);
  assign point_o.cy = sat_word(py_ext + cim_ext);

  // Sequencer: take a request, multiply, then push into the queue.
  always_comb begin
    state_d     = state_q;
    pix_i.ready = 1'b0;
    push_o      = 1'b0;
    case (state_q)
      F_IDLE: begin
        pix_i.ready = 1'b1;
        if (pix_i.valid) state_d = F_MUL;
      end
      F_MUL: begin
        state_d = F_SUM;
      end
      F_SUM: begin
        if (!q_status_i.full) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && pix_i.valid) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (state_q == F_MUL) begin
      px_q <= px_d;
      py_q <= py_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mbe_queue.sv]
`default_nettype none

module mbe_queue
  import mbe_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire point_t   push_data_i,
  input  wire logic     pop_i,
  output point_t        pop_data_o,
  output queue_status_t status_o
);

  point_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr_q, rptr_q;
  logic [QCNT_W-1:0]  count_q;

  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign pop_data_o     = mem_q[rptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

[hw/rtl/mbe_back.sv]
`default_nettype none

module mbe_back
  import mbe_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [ITER_BITS-1:0] max_iter_i,
  input  wire queue_status_t  q_status_i,
  input  wire point_t         point_i,
  output logic                pop_o,
  mbe_res_if.source           res_o
);

  back_state_e state_q, state_d;

  logic signed [WORD_W-1:0] zx_q, zy_q, cx_q, cy_q;
  logic [ITER_BITS-1:0]     n_q;
  logic signed [PROD_W-1:0] pxx_q, pyy_q, pxy_q, pxx_d, pyy_d, pxy_d;
  logic signed [SUM_W-1:0]  xx_ext, yy_ext, xy_ext, cx_ext, cy_ext;
  logic signed [SUM_W-1:0]  mag, nx_sum, ny_sum;
  logic                     escape;
  logic                     load_out;

  logic                  out_valid_q;
  logic [ITER_BITS-1:0]  out_iter_q;

  // Products of the current z.
  assign pxx_d = zx_q * zx_q;
  assign pyy_d = zy_q * zy_q;
  assign pxy_d = zx_q * zy_q;

  // Escape test and next z from the registered products.
  assign xx_ext = pxx_q;
  assign yy_ext = pyy_q;
  assign xy_ext = pxy_q;
  assign cx_ext = cx_q;
  assign cy_ext = cy_q;
  assign mag    = (xx_ext >>> FRAC_BITS) + (yy_ext >>> FRAC_BITS);
  assign escape = (mag > ESCAPE_LIMIT);
  assign nx_sum = (xx_ext >>> FRAC_BITS) - (yy_ext >>> FRAC_BITS) + cx_ext;
  assign ny_sum = (xy_ext >>> (FRAC_BITS - 1)) + cy_ext;

  // Iteration sequencer.
  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o   = 1'b1;
          state_d = B_MUL;
        end
      end
      B_MUL: begin
        state_d = (n_q == max_iter_i) ? B_DONE : B_UPD;
      end
      B_UPD: begin
        state_d = escape ? B_DONE : B_MUL;
      end
      B_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          load_out = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Iteration datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (!q_status_i.empty) begin
          cx_q <= point_i.cx;
          cy_q <= point_i.cy;
          zx_q <= '0;
          zy_q <= '0;
          n_q  <= '0;
        end
      end
      B_MUL: begin
        pxx_q <= pxx_d;
        pyy_q <= pyy_d;
        pxy_q <= pxy_d;
      end
      B_UPD: begin
        if (!escape) begin
          zx_q <= sat_word(nx_sum);
          zy_q <= sat_word(ny_sum);
          n_q  <= n_q + ITER_BITS'(1);
        end
      end
      default: begin
      end
    endcase
    if (load_out) out_iter_q <= n_q;
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.iter_count = out_iter_q;
  assign res_o.shade      = out_iter_q[SHADE_BITS-1:0];

endmodule

`default_nettype wire

[hw/rtl/mandelbrot_escape_time.sv]
// From request to result: the coordinate map, a pop from the queue, loop passes of
// multiply, then test and update (counting the pass that sees the escape; a point that
// reaches the limit ends after a multiply), then a load of the result register. The next
// coordinate map overlaps the iteration loop, so a new pixel can be taken while the last
// one still iterates.
// Reset: view registers take their default values, the queue empties, no result is valid.
`default_nettype none

module mandelbrot_escape_time
  import mbe_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [WORD_W-1:0]    cfg_data_i,
  mbe_pix_if.sink                   pix_i,
  mbe_res_if.source                 res_o
);

  view_cfg_t            view_q;
  logic [ITER_BITS-1:0] max_iter_q;

  logic          push;
  logic          pop;
  point_t        push_point;
  point_t        pop_point;
  queue_status_t q_status;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_q.width     <= RST_WIDTH;
      view_q.height    <= RST_HEIGHT;
      view_q.center_re <= RST_CENTER_RE;
      view_q.center_im <= RST_CENTER_IM;
      view_q.step_re   <= RST_STEP_RE;
      view_q.step_im   <= RST_STEP_IM;
      max_iter_q       <= RST_MAX_ITER;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:  view_q.width     <= cfg_data_i[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: view_q.height    <= cfg_data_i[SIZE_W-1:0];
        REG_CENTER_RE:    view_q.center_re <= signed'(cfg_data_i);
        REG_CENTER_IM:    view_q.center_im <= signed'(cfg_data_i);
        REG_STEP_RE:      view_q.step_re   <= cfg_data_i[STEP_W-1:0];
        REG_STEP_IM:      view_q.step_im   <= cfg_data_i[STEP_W-1:0];
        REG_MAX_ITER:     max_iter_q       <= cfg_data_i[ITER_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  mbe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (view_q),
    .pix_i      (pix_i),
    .q_status_i (q_status),
    .push_o     (push),
    .point_o    (push_point)
  );

  mbe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_point),
    .pop_i       (pop),
    .pop_data_o  (pop_point),
    .status_o    (q_status)
  );

  mbe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .max_iter_i (max_iter_q),
    .q_status_i (q_status),
    .point_i    (pop_point),
    .pop_o      (pop),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire
